### rtl/sfl_pkg.sv
// ----------------------------------------------------------------------------
// sfl_pkg
// Shared types and constants for the streaming substring first/last finder.
// ----------------------------------------------------------------------------
`default_nettype none

package sfl_pkg;

	localparam int MAX_PATTERN = 32;
	localparam int MAX_TEXT    = 65536;

	localparam int BYTE_W  = 8;
	localparam int WIN_W   = MAX_PATTERN * BYTE_W;
	localparam int LEN_W   = $clog2(MAX_PATTERN + 1);
	localparam int POS_W   = $clog2(MAX_TEXT + 1);
	localparam int CMP_W   = 32;

	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 3;
	localparam int PAT_REGS    = 4;
	localparam int PLEN_W      = 6;
	localparam int BOUND_W     = 17;
	localparam int INDEX_W     = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PATTERN_0_7   = 3'd0,
		REG_PATTERN_8_15  = 3'd1,
		REG_PATTERN_16_23 = 3'd2,
		REG_PATTERN_24_31 = 3'd3,
		REG_PATTERN_LEN   = 3'd4,
		REG_SEARCH_MODE   = 3'd5,
		REG_BOUND_INDEX   = 3'd6
	} cfg_reg_t;

	localparam logic MODE_FORWARD = 1'b0;
	localparam logic MODE_REVERSE = 1'b1;

	typedef struct packed {
		logic [PAT_REGS*CFG_DATA_W-1:0] pattern;
		logic [PLEN_W-1:0]              pattern_length;
		logic                           search_mode;
		logic [BOUND_W-1:0]             bound_index;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] text_byte;
		logic              last_byte;
	} in_word_t;

	typedef struct packed {
		logic               found;
		logic [INDEX_W-1:0] match_index;
		logic               status;
	} out_word_t;

endpackage

`default_nettype wire

### rtl/sfl_cfg_regs.sv
// ----------------------------------------------------------------------------
// sfl_cfg_regs
// Configuration register file: pattern bytes, length, mode and bound.
// ----------------------------------------------------------------------------
`default_nettype none

module sfl_cfg_regs
	import sfl_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	output cfg_t                        cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_PATTERN_0_7:   cfg_q.pattern[0*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
				REG_PATTERN_8_15:  cfg_q.pattern[1*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
				REG_PATTERN_16_23: cfg_q.pattern[2*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
				REG_PATTERN_24_31: cfg_q.pattern[3*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
				REG_PATTERN_LEN:   cfg_q.pattern_length <= cfg_data[PLEN_W-1:0];
				REG_SEARCH_MODE:   cfg_q.search_mode <= cfg_data[0];
				REG_BOUND_INDEX:   cfg_q.bound_index <= cfg_data[BOUND_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/sfl_match.sv
// ----------------------------------------------------------------------------
// sfl_match
// Parallel compare of the byte window against the first len pattern bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module sfl_match
	import sfl_pkg::*;
(
	input  wire logic [WIN_W-1:0] window,
	input  wire logic [WIN_W-1:0] pattern,
	input  wire logic [LEN_W-1:0] len,
	output logic                  hit
);

	logic [WIN_W-1:0]       rev;
	logic [WIN_W-1:0]       aligned;
	logic [LEN_W-1:0]       sh;
	logic [MAX_PATTERN-1:0] ok;

	// The newest byte sits at window byte 0. Reversing the window and shifting
	// it down by the unused depth puts the byte that lines up with pattern
	// byte k at byte k.
	always_comb begin
		for (int k = 0; k < MAX_PATTERN; k++) begin
			rev[k*BYTE_W +: BYTE_W] = window[(MAX_PATTERN-1-k)*BYTE_W +: BYTE_W];
		end
		sh      = LEN_W'(MAX_PATTERN) - len;
		aligned = rev >> {sh, 3'b000};
		for (int k = 0; k < MAX_PATTERN; k++) begin
			ok[k] = (aligned[k*BYTE_W +: BYTE_W] == pattern[k*BYTE_W +: BYTE_W])
				|| (LEN_W'(k) >= len);
		end
		hit = (len != '0) && (&ok);
	end

endmodule

`default_nettype wire

### rtl/substring_first_last_finder.sv
// ----------------------------------------------------------------------------
// substring_first_last_finder
// Streams text bytes and reports the first or last match of a pattern.
// ----------------------------------------------------------------------------
//  channel  | direction | word
//  in       | sink      | text_byte, last_byte
//  out      | source    | found, match_index, status (one per text)
//  cfg      | sink      | register index, 64-bit data
//
// One byte is accepted per cycle unless the input stalls. A byte is held in
// the input register, where the window compare and match bookkeeping take
// place; the final byte of a text loads the result register as it leaves.
// Input stalls only when a result is waiting and the next final byte needs
// the result register. Reset clears the configuration and the stream state.
// ----------------------------------------------------------------------------
`default_nettype none

module substring_first_last_finder
	import sfl_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire in_word_t               in_data,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output out_word_t                   out_data,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t cfg;

	logic              valid_s1;
	in_word_t          word_s1;
	logic [WIN_W-1:0]  win_q;
	logic [POS_W-1:0]  pos_q;
	logic              seen_q;
	logic [INDEX_W-1:0] start_q;
	logic              out_valid_q;
	out_word_t         out_data_q;

	logic              advance;
	logic              text_ok;
	logic [LEN_W-1:0]  len;
	logic [WIN_W-1:0]  win_new;
	logic [POS_W-1:0]  pos_new;
	logic [POS_W-1:0]  start_pos;
	logic              hit;
	logic              take;
	logic              seen_new;
	logic [INDEX_W-1:0] start_new;
	logic              bad;
	out_word_t         result;

	sfl_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sfl_match u_match (
		.window  (win_new),
		.pattern (cfg.pattern[WIN_W-1:0]),
		.len     (len),
		.hit     (hit)
	);

	assign advance   = valid_s1 && (!word_s1.last_byte || !out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		if (CMP_W'(cfg.pattern_length) > CMP_W'(MAX_PATTERN)) begin
			len = LEN_W'(MAX_PATTERN);
		end else begin
			len = LEN_W'(cfg.pattern_length);
		end

		text_ok = CMP_W'(pos_q) < CMP_W'(MAX_TEXT);
		if (text_ok) begin
			win_new = {win_q[WIN_W-BYTE_W-1:0], word_s1.text_byte};
			pos_new = pos_q + POS_W'(1);
		end else begin
			win_new = win_q;
			pos_new = pos_q;
		end
		start_pos = pos_new - POS_W'(len);

		take = text_ok && (len != '0) && (CMP_W'(pos_new) >= CMP_W'(len)) && hit;
		seen_new  = seen_q;
		start_new = start_q;
		if (take) begin
			if (cfg.search_mode == MODE_FORWARD) begin
				if (!seen_q && (CMP_W'(start_pos) >= CMP_W'(cfg.bound_index))) begin
					seen_new  = 1'b1;
					start_new = start_pos[INDEX_W-1:0];
				end
			end else begin
				if (CMP_W'(pos_new) <= CMP_W'(cfg.bound_index)) begin
					seen_new  = 1'b1;
					start_new = start_pos[INDEX_W-1:0];
				end
			end
		end

		if (cfg.search_mode == MODE_FORWARD) begin
			bad = CMP_W'(cfg.bound_index) >= CMP_W'(pos_new);
		end else begin
			bad = CMP_W'(cfg.bound_index) > CMP_W'(pos_new);
		end

		if (bad) begin
			result.found       = 1'b0;
			result.match_index = '0;
			result.status      = 1'b1;
		end else begin
			result.found       = seen_new;
			result.match_index = seen_new ? start_new : '0;
			result.status      = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			pos_q   <= '0;
			seen_q  <= 1'b0;
			start_q <= '0;
		end else if (advance) begin
			win_q <= win_new;
			if (word_s1.last_byte) begin
				pos_q   <= '0;
				seen_q  <= 1'b0;
				start_q <= '0;
			end else begin
				pos_q   <= pos_new;
				seen_q  <= seen_new;
				start_q <= start_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && word_s1.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && word_s1.last_byte) begin
			out_data_q <= result;
		end
	end

endmodule

`default_nettype wire

### bench/substring_first_last_finder_test.sv
// ----------------------------------------------------------------------------
// substring_first_last_finder_test
// Self-checking bench for the streaming substring finder. Byte streams are
// sent with random gaps and stalls on both sides. A tracker inside the bench
// keeps its own pattern registers, byte window and match state, predicts the
// result word of every text and compares it field by field with the block.
// ----------------------------------------------------------------------------
module substring_first_last_finder_test;
	import sfl_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_BYTES = 1500;
	localparam int HOLD_CYCLES = 400;

	class match_tracker;
		logic [CFG_DATA_W-1:0] pattern_reg [PAT_REGS] = '{default: '0};
		logic [PLEN_W-1:0]     pattern_length = '0;
		logic                  search_mode = MODE_FORWARD;
		logic [BOUND_W-1:0]    bound_index = '0;
		logic [BYTE_W-1:0]     window [MAX_PATTERN] = '{default: '0};
		logic [POS_W-1:0]      position = '0;
		logic                  match_seen = 1'b0;
		logic [INDEX_W-1:0]    match_start = '0;
		out_word_t             pending_results [$];
		int                    errors = 0;

		function void write_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_PATTERN_0_7: pattern_reg[0] = data;
				REG_PATTERN_8_15: pattern_reg[1] = data;
				REG_PATTERN_16_23: pattern_reg[2] = data;
				REG_PATTERN_24_31: pattern_reg[3] = data;
				REG_PATTERN_LEN: pattern_length = data[PLEN_W-1:0];
				REG_SEARCH_MODE: search_mode = data[0];
				REG_BOUND_INDEX: bound_index = data[BOUND_W-1:0];
				default: ;
			endcase
		endfunction

		function void clear_text();
			int i;
			for (i = 0; i < MAX_PATTERN; i++)
				window[i] = '0;
			position = '0;
			match_seen = 1'b0;
			match_start = '0;
		endfunction

		function void take_byte(in_word_t w);
			int len, i, start;
			bit hit, bad;
			out_word_t res;
			len = (pattern_length > MAX_PATTERN) ? MAX_PATTERN : int'(pattern_length);
			if (position < MAX_TEXT) begin
				for (i = MAX_PATTERN - 1; i > 0; i--)
					window[i] = window[i-1];
				window[0] = w.text_byte;
				position = position + 1'b1;
				if (len != 0 && int'(position) >= len) begin
					hit = 1'b1;
					for (i = 0; i < len; i++)
						if (window[len-1-i] != pattern_reg[i/8][(i%8)*8 +: 8])
							hit = 1'b0;
					if (hit) begin
						start = int'(position) - len;
						if (search_mode == MODE_FORWARD) begin
							if (!match_seen && start >= int'(bound_index)) begin
								match_seen = 1'b1;
								match_start = start[INDEX_W-1:0];
							end
						end else if (int'(position) <= int'(bound_index)) begin
							match_seen = 1'b1;
							match_start = start[INDEX_W-1:0];
						end
					end
				end
			end
			if (w.last_byte) begin
				if (search_mode == MODE_FORWARD)
					bad = int'(bound_index) >= int'(position);
				else
					bad = int'(bound_index) > int'(position);
				res.found = bad ? 1'b0 : match_seen;
				res.match_index = (bad || !match_seen) ? '0 : match_start;
				res.status = bad;
				pending_results.push_back(res);
				clear_text();
			end
		endfunction

		function void check_result(out_word_t got);
			out_word_t want;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected word found %0b index %0d status %0b",
					$time, got.found, got.match_index, got.status);
				return;
			end
			want = pending_results.pop_front();
			if (got.found !== want.found) begin
				errors++;
				$display("%0t: found expected %0b actual %0b", $time, want.found, got.found);
			end
			if (got.match_index !== want.match_index) begin
				errors++;
				$display("%0t: match_index expected %0d actual %0d",
					$time, want.match_index, got.match_index);
			end
			if (got.status !== want.status) begin
				errors++;
				$display("%0t: status expected %0b actual %0b", $time, want.status, got.status);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_word_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	match_tracker tracker;
	logic [BYTE_W-1:0] text_buf [$];
	logic [PAT_REGS*CFG_DATA_W-1:0] pattern_now = '0;
	int plen_now = 0;
	int bytes_sent = 0;
	int quiet_cycles = 0;
	bit no_gaps = 1'b0;
	bit hold_req = 1'b0;

	substring_first_last_finder uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				tracker.check_result(out_data);
			if (hold_req && hold_left == 0) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else
				out_ready <= no_gaps || ($urandom_range(0, 99) >= 35);
		end
	end

	task automatic send_word(in_word_t w);
		while (!no_gaps && $urandom_range(0, 99) < 35) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do
			@(posedge clk);
		while (!in_ready);
		tracker.take_byte(w);
		bytes_sent++;
	endtask

	task automatic send_text();
		int k;
		in_word_t w;
		for (k = 0; k < text_buf.size(); k++) begin
			w.text_byte = text_buf[k];
			w.last_byte = (k == text_buf.size() - 1);
			send_word(w);
		end
	endtask

	task automatic fill_text(int length, bit wide, int copies);
		int eff, at, k, c;
		eff = (plen_now > MAX_PATTERN) ? MAX_PATTERN : plen_now;
		text_buf.delete();
		for (k = 0; k < length; k++)
			text_buf.push_back(wide ? 8'($urandom_range(0, 255))
				: 8'(8'h61 + $urandom_range(0, 2)));
		for (c = 0; c < copies; c++)
			if (eff != 0 && eff <= length) begin
				at = $urandom_range(0, length - eff);
				for (k = 0; k < eff; k++)
					text_buf[at+k] = pattern_now[8*k +: 8];
			end
	endtask

	task automatic drain(int settle);
		while (tracker.pending_results.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		tracker.write_register(idx, data);
	endtask

	task automatic configure(logic [PAT_REGS*CFG_DATA_W-1:0] pat, int plen, logic mode,
			int bound);
		in_valid <= 1'b0;
		drain(4);
		write_reg(REG_PATTERN_0_7, pat[63:0]);
		write_reg(REG_PATTERN_8_15, pat[127:64]);
		write_reg(REG_PATTERN_16_23, pat[191:128]);
		write_reg(REG_PATTERN_24_31, pat[255:192]);
		write_reg(REG_PATTERN_LEN, 64'(plen));
		write_reg(REG_SEARCH_MODE, 64'(mode));
		write_reg(REG_BOUND_INDEX, 64'(bound));
		cfg_valid <= 1'b0;
		pattern_now = pat;
		plen_now = plen;
	endtask

	initial begin : stimulus
		logic [PAT_REGS*CFG_DATA_W-1:0] pat;
		logic mode;
		int plen, bound, pick, length, k, start_count;
		bit wide;

		tracker = new;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset configuration has an empty pattern, so nothing can be found.
		text_buf = '{8'h00};
		send_text();

		text_buf = '{8'hff, 8'h00, 8'hff, 8'h00};
		configure(256'h00ff, 2, MODE_FORWARD, 0);
		send_text();
		configure(256'h00ff, 2, MODE_FORWARD, 4);
		send_text();
		configure(256'h00ff, 2, MODE_REVERSE, 4);
		send_text();
		configure(256'h00ff, 2, MODE_REVERSE, 3);
		send_text();
		configure(256'h00ff, 2, MODE_REVERSE, 5);
		send_text();
		configure(256'h00ff, 2, MODE_REVERSE, 1);
		send_text();

		// Results are held back while short texts keep arriving.
		configure(256'h61, 1, MODE_FORWARD, 0);
		hold_req = 1'b1;
		no_gaps = 1'b1;
		repeat (40) begin
			fill_text($urandom_range(1, 3), 1'b0, 1);
			send_text();
		end
		no_gaps = 1'b0;

		start_count = bytes_sent;
		while (bytes_sent - start_count < RANDOM_BYTES) begin
			no_gaps = (bytes_sent - start_count >= 600) && (bytes_sent - start_count < 900);
			if ($urandom_range(0, 99) < 40) begin
				wide = ($urandom_range(0, 4) == 0);
				for (k = 0; k < MAX_PATTERN; k++)
					pat[8*k +: 8] = wide ? 8'($urandom_range(0, 255))
						: 8'(8'h61 + $urandom_range(0, 2));
				pick = $urandom_range(0, 19);
				if (pick == 0)
					plen = 0;
				else if (pick == 1)
					plen = MAX_PATTERN;
				else if (pick == 2)
					plen = $urandom_range(MAX_PATTERN + 1, 63);
				else if (pick == 3)
					plen = $urandom_range(7, MAX_PATTERN - 1);
				else
					plen = $urandom_range(1, 6);
				mode = $urandom_range(0, 1);
				pick = $urandom_range(0, 9);
				if (pick == 0)
					bound = 0;
				else if (pick == 1)
					bound = MAX_TEXT;
				else if (pick == 2)
					bound = $urandom_range(0, MAX_TEXT);
				else
					bound = $urandom_range(0, 40);
				configure(pat, plen, mode, bound);
			end
			length = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 100)
				: $urandom_range(1, 40);
			fill_text(length, $urandom_range(0, 4) == 0, $urandom_range(0, 2));
			send_text();
		end
		no_gaps = 1'b0;

		in_valid <= 1'b0;
		drain(20);
		if (tracker.errors == 0 && tracker.pending_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
